// ===== hdl/windowed_peak_convergence_detector_macros.svh =====
// ----------------------------------------------------------------------------
// windowed peak convergence detector: assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PEAK_CONVERGENCE_DETECTOR_MACROS_SVH
`define WINDOWED_PEAK_CONVERGENCE_DETECTOR_MACROS_SVH

// same-cycle implication
`define WPCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WPCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpcd_pkg
// widths, constants and request types of the windowed peak convergence detector
// ----------------------------------------------------------------------------
package wpcd_pkg;

	localparam int WINDOW  = 16;
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PEAK_W  = 31;
	localparam int DELTA_W = 32;
	localparam int COUNT_W = 32;
	localparam int SUM_W   = PEAK_W + $clog2(WINDOW + 1);
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [PEAK_W-1:0]  peak_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [COUNT_W-1:0] count_t;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MIN_ITER  = 2'd0,
		REG_MAX_ITER  = 2'd1,
		REG_THRESHOLD = 2'd2
	} reg_idx_t;

	localparam count_t MIN_ITER_RST  = '0;
	localparam count_t MAX_ITER_RST  = '1;
	localparam peak_t  THRESHOLD_RST = PEAK_W'(65536);
	localparam count_t COUNT_MAX     = '1;
	localparam slot_t  SLOT_LAST     = SLOT_W'(WINDOW - 1);
	localparam count_t WINDOW_COUNT  = COUNT_W'(WINDOW);

	typedef struct packed {
		logic  en;
		slot_t addr;
	} rd_req_t;

	typedef struct packed {
		logic  en;
		slot_t addr;
		peak_t data;
	} wr_req_t;

endpackage

// ===== hdl/wpcd_if.sv =====
// ----------------------------------------------------------------------------
// wpcd channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface wpcd_item_if;
	import wpcd_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic signed [DELTA_W-1:0] delta;

	modport source (output valid, output action, output delta, input ready);
	modport sink   (input valid, input action, input delta, output ready);
endinterface

interface wpcd_result_if;
	import wpcd_pkg::*;

	logic   valid;
	logic   ready;
	logic   converged;
	count_t iteration_count;

	modport source (output valid, output converged, output iteration_count, input ready);
	modport sink   (input valid, input converged, input iteration_count, output ready);
endinterface

// ===== hdl/wpcd_ring.sv =====
// ----------------------------------------------------------------------------
// wpcd_ring
// ring of per-iteration peaks: registered read, write port, valid bits, bypass
// ----------------------------------------------------------------------------
module wpcd_ring
	import wpcd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t rd,
	input  wr_req_t wr,
	output peak_t   rdata
);

	peak_t              mem [WINDOW];
	logic [WINDOW-1:0]  vld_q;
	peak_t              mem_rd_q;
	logic               ent_vld_q;
	logic               byp_q;
	peak_t              byp_data_q;

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// same-edge write to the read slot wins
	always_ff @(posedge clk) begin
		if (rd.en) begin
			mem_rd_q   <= mem[rd.addr];
			ent_vld_q  <= vld_q[rd.addr];
			byp_q      <= wr.en && (wr.addr == rd.addr);
			byp_data_q <= wr.data;
		end
	end

	assign rdata = byp_q ? byp_data_q : (ent_vld_q ? mem_rd_q : '0);

endmodule

// ===== hdl/windowed_peak_convergence_detector.sv =====
// ----------------------------------------------------------------------------
// windowed_peak_convergence_detector
// convergence detector for iterative solvers over a ring of iteration peaks
// ----------------------------------------------------------------------------
// Each request is a sample (action 0, signed Q15.16 delta) or an end-of-
// iteration tick (action 1). A sample raises the peak of the current ring
// slot to its magnitude (saturated to 31 bits); a tick bumps the saturating
// iteration counter, steps to the next slot and clears it. Every request
// yields one result: the iteration count and a converged flag. The block
// takes one request per clock cycle while the result side is not stalled; each
// request passes stage 1, then the result register. The rate is set by the
// ring memory: its slot is read in the accept cycle and written back when
// stage 1 advances, with a same-cycle bypass for back-to-back requests that
// hit one slot. The ring is clear right out of reset (per-slot valid bits),
// with no clearing pass. Configuration writes go through cfg_we, cfg_index
// and cfg_wdata and are to be made while no request is in flight.
module windowed_peak_convergence_detector
	import wpcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	wpcd_item_if.sink          items,
	wpcd_result_if.source      results
);

`include "windowed_peak_convergence_detector_macros.svh"

	// configuration registers
	count_t min_q;
	count_t max_q;
	peak_t  thr_q;

	// architectural state: slot and counter updated at accept time, sum at write-back
	slot_t  pos_q;
	count_t cnt_q;
	sum_t   sum_q;

	// stage 1: ring read data comes back here
	logic   vld_s1;
	logic   act_s1;
	peak_t  mag_s1;
	slot_t  addr_s1;
	count_t cnt_s1;

	// result register
	logic   res_vld_q;
	logic   res_conv_q;
	count_t res_cnt_q;

	logic    in_acc;
	logic    adv;
	slot_t   pos_nxt;
	logic [DELTA_W-1:0] neg_delta;
	logic [DELTA_W-1:0] abs_delta;
	peak_t   mag;
	peak_t   peak;
	peak_t   wdata;
	sum_t    sum_nxt;
	count_t  lo_lim;
	count_t  hi_lim;
	sum_t    thr_win;
	logic    conv;
	rd_req_t rd;
	wr_req_t wr;

	// config writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_ITER_RST;
			max_q <= MAX_ITER_RST;
			thr_q <= THRESHOLD_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_ITER:  min_q <= cfg_wdata;
				REG_MAX_ITER:  max_q <= cfg_wdata;
				REG_THRESHOLD: thr_q <= cfg_wdata[PEAK_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or drains
	assign adv          = !res_vld_q || results.ready;
	assign items.ready  = !vld_s1 || adv;
	assign in_acc       = items.valid && items.ready;

	// slot for this request: ticks step to the next slot
	always_comb begin
		pos_nxt = pos_q;
		if (items.action) begin
			pos_nxt = (pos_q == SLOT_LAST) ? '0 : pos_q + 1'b1;
		end
	end

	// magnitude with the most negative value saturated
	assign neg_delta = DELTA_W'(-items.delta);
	assign abs_delta = items.delta[DELTA_W-1] ? neg_delta : items.delta;
	assign mag       = abs_delta[DELTA_W-1] ? '1 : abs_delta[PEAK_W-1:0];

	assign rd.en   = in_acc;
	assign rd.addr = pos_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else if (in_acc) begin
			pos_q <= pos_nxt;
			if (items.action && (cnt_q != COUNT_MAX)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// counter after this request travels with it
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1  <= items.action;
			mag_s1  <= mag;
			addr_s1 <= pos_nxt;
			cnt_s1  <= (items.action && (cnt_q != COUNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
		end
	end

	wpcd_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.wr     (wr),
		.rdata  (peak)
	);

	// read-modify-write of the slot and the running sum
	always_comb begin
		wdata   = peak;
		sum_nxt = sum_q;
		if (act_s1) begin
			wdata   = '0;
			sum_nxt = sum_q - SUM_W'(peak);
		end else if (mag_s1 > peak) begin
			wdata   = mag_s1;
			sum_nxt = sum_q + SUM_W'(mag_s1 - peak);
		end
	end

	assign wr.en   = vld_s1 && adv;
	assign wr.addr = addr_s1;
	assign wr.data = wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (wr.en) begin
			sum_q <= sum_nxt;
		end
	end

	// convergence rule: below the floor never, at the ceiling always,
	// otherwise the windowed sum against threshold times the window
	assign lo_lim  = (min_q < WINDOW_COUNT) ? WINDOW_COUNT : min_q;
	assign hi_lim  = (max_q < WINDOW_COUNT) ? WINDOW_COUNT : max_q;
	assign thr_win = SUM_W'(SUM_W'(thr_q) * SUM_W'(WINDOW));

	always_comb begin
		if (cnt_s1 < lo_lim) begin
			conv = 1'b0;
		end else if (cnt_s1 >= hi_lim) begin
			conv = 1'b1;
		end else begin
			conv = sum_nxt < thr_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			res_conv_q <= conv;
			res_cnt_q  <= cnt_s1;
		end
	end

	assign results.valid           = res_vld_q;
	assign results.converged       = res_conv_q;
	assign results.iteration_count = res_cnt_q;

	// counter moves only on an accepted tick
	`WPCD_ASSERT_NEXT(a_cnt_hold, !(in_acc && items.action), $stable(cnt_q), "counter moved without a tick")
	// a tick always leaves the slot it was on
	`WPCD_ASSERT_NEXT(a_slot_step, in_acc && items.action, pos_q != $past(pos_q), "tick did not advance the slot")
	// never converged before a full window of iterations
	`WPCD_ASSERT_NOW(a_min_window, results.valid && (results.iteration_count < WINDOW_COUNT), !results.converged, "converged before a full window")

endmodule
